// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for clocked concurrent assertions with async reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hwrs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hwrs_pkg
// Shared sizes, codes and FSM states of the wait ratio selector.
// ---------------------------------------------------------------------------
package hwrs_pkg;

	localparam int ENTRIES     = 64;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int ENTRY_IDX_W = 6;
	localparam int CHOSEN_W    = 6;
	localparam int TICK_W      = 32;
	localparam int BIT_CNT_W   = $clog2(TICK_W);

	// index compare width: must hold both the request index and ENTRIES
	localparam int CMP_W = (IDX_W + 1 > ENTRY_IDX_W) ? IDX_W + 1 : ENTRY_IDX_W;
	// width used to fit the winning index into the output field
	localparam int CHOSEN_EXT_W = (IDX_W > CHOSEN_W) ? IDX_W : CHOSEN_W;

	// input word layout, lowest bit first
	localparam int OFS_INDEX    = 0;
	localparam int OFS_RUNNABLE = OFS_INDEX + ENTRY_IDX_W;
	localparam int OFS_START    = OFS_RUNNABLE + 1;
	localparam int OFS_RUNS     = OFS_START + TICK_W;
	localparam int OFS_NOW      = OFS_RUNS + TICK_W;
	localparam int S_DATA_W     = ((OFS_NOW + TICK_W + 7) / 8) * 8;
	localparam int M_DATA_W     = ((CHOSEN_W + 7) / 8) * 8;

	// table word: run ticks above creation tick
	localparam int ENTRY_W = 2 * TICK_W;

	localparam logic [TICK_W-1:0] NO_RUN_SCORE = TICK_W'(99999999);

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_DIV,
		ST_SCORE,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/hwrs_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hwrs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module hwrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/highest_wait_ratio_selector.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// highest_wait_ratio_selector
// Task table with a highest wait-ratio pick, scored by a bit-serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word per request. s_tuser is the request kind
//   (write or select). A write stores runnable flag, creation tick and run
//   ticks into one table entry and returns nothing; writes past the table
//   are dropped. A select carries the current tick and returns one word.
//   Output channel m_*: chosen entry in m_tdata, none-runnable flag in
//   m_tuser (index reads 0 when the flag is set).
// Sequencing:
//   A write is taken while idle; writes may arrive back to back.
//   A select scans all entries in order: an idle entry only passes the
//   scan state; a runnable entry with zero run ticks adds load and score;
//   any other runnable entry adds table read, load, the one-bit-per-cycle
//   restoring divider and compare.
//   s_tready is low while a select is scanned.
// Reset:
//   arst_n clears all runnable flags and the output valid; table words are
//   only read for runnable entries, which have always been written.
// Stall:
//   The result sits in an output register; while m_tready is low, new writes
//   are still taken. A second select finishes its scan and then waits in
//   its final state until the register frees.
// ---------------------------------------------------------------------------
module highest_wait_ratio_selector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_index, entry_runnable, entry_start_tick, entry_run_ticks,
	// current_tick, zero pad
	input  logic [hwrs_pkg::S_DATA_W-1:0] s_tdata,
	// req_type
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// chosen_index, zero pad
	output logic [hwrs_pkg::M_DATA_W-1:0] m_tdata,
	// none_runnable
	output logic                          m_tuser
);

	import hwrs_pkg::*;

	// input word fields
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic                   entry_runnable;
	logic [TICK_W-1:0]      entry_start_tick;
	logic [TICK_W-1:0]      entry_run_ticks;
	logic [TICK_W-1:0]      current_tick;

	assign entry_index      = s_tdata[OFS_INDEX +: ENTRY_IDX_W];
	assign entry_runnable   = s_tdata[OFS_RUNNABLE];
	assign entry_start_tick = s_tdata[OFS_START +: TICK_W];
	assign entry_run_ticks  = s_tdata[OFS_RUNS +: TICK_W];
	assign current_tick     = s_tdata[OFS_NOW +: TICK_W];

	state_t state_q, state_d;

	// control
	logic [ENTRIES-1:0] ready_q;     // runnable flag per entry
	logic [IDX_W-1:0]   cnt_q;       // scan position
	logic               out_vld_q;
	logic               s_fire;
	logic               sel_req;
	logic               in_range;
	logic               wr_fire;
	logic               last_entry;
	logic               out_take;
	logic               rd_en;
	logic [CMP_W-1:0]   idx_ext;
	logic [IDX_W-1:0]   wr_addr;

	// datapath
	logic [TICK_W-1:0]        now_q;
	logic [TICK_W-1:0]        rem_q;   // partial remainder
	logic [TICK_W-1:0]        dvd_q;   // dividend out, quotient in
	logic [TICK_W-1:0]        div_q;   // divisor
	logic [BIT_CNT_W-1:0]     bit_q;
	logic [TICK_W-1:0]        best_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     found_q;
	logic [CHOSEN_W-1:0]      out_idx_q;
	logic                     out_none_q;
	logic [ENTRY_W-1:0]       rd_data;
	logic [TICK_W-1:0]        rd_start;
	logic [TICK_W-1:0]        rd_runs;
	logic [TICK_W:0]          rem_shift;
	logic [TICK_W+1:0]        trial;
	logic                     borrow;
	logic [CHOSEN_EXT_W-1:0]  best_ext;

	assign s_fire     = s_tvalid && s_tready;
	assign sel_req    = (s_tuser == REQ_SELECT);
	assign idx_ext    = CMP_W'(entry_index);
	assign in_range   = idx_ext < CMP_W'(ENTRIES);
	assign wr_addr    = idx_ext[IDX_W-1:0];
	assign wr_fire    = s_fire && (s_tuser == REQ_WRITE) && in_range;
	assign last_entry = (cnt_q == IDX_W'(ENTRIES - 1));
	assign out_take   = !out_vld_q || m_tready;

	assign rd_start = rd_data[TICK_W-1:0];
	assign rd_runs  = rd_data[ENTRY_W-1:TICK_W];

	// one restoring division step
	assign rem_shift = {rem_q, dvd_q[TICK_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, div_q};
	assign borrow    = trial[TICK_W+1];

	assign best_ext = CHOSEN_EXT_W'(best_idx_q);

	// creation tick and run ticks per entry
	hwrs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_fire),
		.wr_addr(wr_addr),
		.wr_data({entry_run_ticks, entry_start_tick}),
		.rd_en  (rd_en),
		.rd_addr(cnt_q),
		.rd_data(rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire && sel_req) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (ready_q[cnt_q])  state_d = ST_LOAD;
				else if (last_entry) state_d = ST_DONE;
			end
			ST_LOAD: begin
				state_d = (rd_runs == '0) ? ST_SCORE : ST_DIV;
			end
			ST_DIV: begin
				if (bit_q == BIT_CNT_W'(TICK_W - 1)) state_d = ST_SCORE;
			end
			ST_SCORE: begin
				state_d = last_entry ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				if (out_take) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// FSM outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: rd_en    = ready_q[cnt_q];
			default: begin
				s_tready = 1'b0;
				rd_en    = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ready_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_fire) begin
				ready_q[wr_addr] <= entry_runnable;
			end
			if (state_q == ST_DONE && out_take) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// scan, divider and best tracking
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire && sel_req) begin
					now_q      <= current_tick;
					cnt_q      <= '0;
					found_q    <= 1'b0;
					best_q     <= '0;
					best_idx_q <= '0;
				end
			end
			ST_SCAN: begin
				if (!ready_q[cnt_q] && !last_entry) cnt_q <= cnt_q + 1'b1;
			end
			ST_LOAD: begin
				rem_q <= '0;
				bit_q <= '0;
				div_q <= rd_runs;
				dvd_q <= (rd_runs == '0) ? NO_RUN_SCORE : now_q - rd_start;
			end
			ST_DIV: begin
				rem_q <= borrow ? rem_shift[TICK_W-1:0] : trial[TICK_W-1:0];
				dvd_q <= {dvd_q[TICK_W-2:0], !borrow};
				bit_q <= bit_q + 1'b1;
			end
			ST_SCORE: begin
				// first runnable entry always taken; later only if strictly greater
				if (!found_q || dvd_q > best_q) begin
					best_q     <= dvd_q;
					best_idx_q <= cnt_q;
				end
				found_q <= 1'b1;
				if (!last_entry) cnt_q <= cnt_q + 1'b1;
			end
			ST_DONE: begin
				if (out_take) begin
					out_idx_q  <= best_ext[CHOSEN_W-1:0];
					out_none_q <= !found_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = M_DATA_W'(out_idx_q);
	assign m_tuser  = out_none_q;

endmodule

// ===== rtl/hwrs_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hwrs_checker
// Port-level checks of the wait ratio selector, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hwrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [hwrs_pkg::S_DATA_W-1:0] s_tdata,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hwrs_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	import hwrs_pkg::*;

	// stalled result word holds
	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// none runnable reports index zero
	`CHK_SAME(a_none_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0, "none-runnable with nonzero index")

	// a select starts a scan that blocks the input
	`CHK_NEXT(a_sel_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser == REQ_SELECT), !s_tready, "input ready right after a select")

	// a write never brings a result
	`CHK_NEXT(a_wr_silent, clk, arst_n, s_tvalid && s_tready && (s_tuser == REQ_WRITE) && !m_tvalid, !m_tvalid, "result after a write")

endmodule

bind highest_wait_ratio_selector hwrs_checker u_hwrs_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for highest_wait_ratio_selector.
// ---------------------------------------------------------------------------
// Keeps a shadow copy of the task table and works out the pick for every
// select word as it is accepted. Each output word is compared against the
// oldest pending pick. A directed part covers the empty table, zero run
// ticks, ties, tick wrap and field extremes; random traffic then runs under
// several idle/stall mixes, with one pause that lets all picks drain.
// ---------------------------------------------------------------------------
module tb;

	import hwrs_pkg::S_DATA_W;
	import hwrs_pkg::M_DATA_W;
	import hwrs_pkg::REQ_WRITE;
	import hwrs_pkg::REQ_SELECT;

	localparam int          TABLE_SIZE   = 64;
	localparam logic [31:0] NO_RUN_RATIO = 32'd99999999;
	localparam int unsigned RUN_LIMIT    = 3000000;
	localparam int          SETTLE_CYC   = 2500;  // longer than one full scan
	localparam int          MAX_PRINTS   = 40;

	typedef struct packed {
		logic [5:0] chosen;
		logic       none;
	} pick_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	// shadow task table
	bit          task_ready [TABLE_SIZE];
	logic [31:0] task_born  [TABLE_SIZE];
	logic [31:0] task_ran   [TABLE_SIZE];

	pick_t       pending_picks [$];
	int          mismatches;
	int unsigned cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic [31:0] tick_clock;

	highest_wait_ratio_selector i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch %s: got %0h, want %0h (cycle %0d)",
				what, got, want, cycle_count);
		mismatches++;
	endtask

	// highest wait ratio over the shadow table; first of equal scores wins
	function automatic pick_t predict_pick(logic [31:0] now);
		logic [31:0] ratio;
		logic [31:0] top;
		bit          found;
		pick_t       p;
		found    = 1'b0;
		top      = '0;
		p.chosen = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (!task_ready[i])
				continue;
			ratio = (task_ran[i] == 0) ? NO_RUN_RATIO : (now - task_born[i]) / task_ran[i];
			if (!found || ratio > top) begin
				found    = 1'b1;
				top      = ratio;
				p.chosen = 6'(i);
			end
		end
		p.none = !found;
		return p;
	endfunction

	// drive one word, wait for the handshake, then update the shadow table
	task automatic send_request(logic kind, logic [5:0] idx, logic runnable,
			logic [31:0] born, logic [31:0] ran, logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= S_DATA_W'({now, ran, born, runnable, idx});
		do @(posedge clk); while (!s_tready);
		if (kind == REQ_WRITE) begin
			if (idx < TABLE_SIZE) begin
				task_ready[idx] = runnable;
				task_born[idx]  = born;
				task_ran[idx]   = ran;
			end
		end else begin
			pending_picks.push_back(predict_pick(now));
		end
	endtask

	task automatic write_entry(logic [5:0] idx, logic runnable, logic [31:0] born,
			logic [31:0] ran);
		send_request(REQ_WRITE, idx, runnable, born, ran, $urandom());
	endtask

	// unused write fields carry noise on selects
	task automatic select_at(logic [31:0] now);
		send_request(REQ_SELECT, 6'($urandom_range(63)), 1'($urandom_range(1)),
			$urandom(), $urandom(), now);
	endtask

	// result checker and receiver back-pressure
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_picks.size() == 0) begin
				report_mismatch("unexpected word", 32'(m_tdata), 32'(m_tuser));
			end else begin
				want = pending_picks.pop_front();
				if (m_tdata !== M_DATA_W'(want.chosen))
					report_mismatch("chosen_index", 32'(m_tdata), 32'(want.chosen));
				if (m_tuser !== want.none)
					report_mismatch("none_runnable", 32'(m_tuser), 32'(want.none));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [31:0] pick_born();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return $urandom();
			default: return tick_clock - $urandom_range(0, 100000);
		endcase
	endfunction

	function automatic logic [31:0] pick_ran();
		case ($urandom_range(19))
			0, 1, 2: return '0;
			3:       return '1;
			4, 5:    return 32'd1;
			6, 7, 8: return $urandom_range(1, 20);
			9, 10, 11, 12, 13: return $urandom_range(1, 5000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_now();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2:       return $urandom();
			default: return tick_clock;
		endcase
	endfunction

	task automatic test_empty_table();
		send_request(REQ_SELECT, '1, 1'b1, '1, '1, '1);
	endtask

	task automatic test_zero_run_ticks();
		write_entry(6'd5, 1'b1, 32'd0, 32'd0);
		write_entry(6'd9, 1'b1, 32'd0, 32'd1);
		select_at('1);       // full-range ratio beats the no-run score
		select_at(32'd1000); // no-run score wins
		write_entry(6'd5, 1'b0, '1, '1);
		write_entry(6'd9, 1'b0, '1, '1);
	endtask

	task automatic test_tie_break();
		write_entry(6'd63, 1'b1, 32'd0, 32'd1);
		write_entry(6'd62, 1'b1, 32'd0, 32'd1);
		select_at(32'd50);
	endtask

	task automatic test_tick_wrap();
		// now below creation tick: wait time wraps to 32
		write_entry(6'd0, 1'b1, 32'hFFFF_FFF0, 32'd2);
		select_at(32'd16);
	endtask

	task automatic test_field_extremes();
		write_entry(6'd1, 1'b1, '1, '1);
		select_at(32'hFFFF_FFFE);
		write_entry(6'd0, 1'b0, '0, '0);
		write_entry(6'd1, 1'b0, '1, '1);
		write_entry(6'd62, 1'b0, '0, '1);
		write_entry(6'd63, 1'b0, '1, '0);
		select_at($urandom());
	endtask

	task automatic test_random_mix(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 30) begin
				tick_clock += $urandom_range(0, 5000);
				select_at(pick_now());
			end else begin
				write_entry(6'($urandom_range(63)), 1'($urandom_range(99) < 55),
					pick_born(), pick_ran());
			end
		end
	endtask

	// sender holds off until every pick is back, then resumes
	task automatic test_drain_pause();
		write_entry(6'($urandom_range(63)), 1'b1, pick_born(), pick_ran());
		write_entry(6'($urandom_range(63)), 1'b1, pick_born(), pick_ran());
		select_at(tick_clock);
		s_tvalid <= 1'b0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		select_at(tick_clock + 32'd7);
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = REQ_WRITE;
		mismatches     = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		tick_clock     = 32'hFFFF_FFFF - $urandom_range(0, 300000);
		for (int i = 0; i < TABLE_SIZE; i++) begin
			task_ready[i] = 1'b0;
			task_born[i]  = '0;
			task_ran[i]   = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_zero_run_ticks();
		test_tie_break();
		test_tick_wrap();
		test_field_extremes();

		test_random_mix(70);
		send_idle_pct = 55;
		test_random_mix(65);
		test_drain_pause();
		send_idle_pct  = 0;
		recv_stall_pct = 55;
		test_random_mix(65);
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		test_random_mix(60);

		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		while (pending_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
